// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define BHW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that, once seen, must be followed by the consequence in the next cycle
`define BHW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bhw_pkg.sv =====
`default_nettype none

package bhw_pkg;

    // Field widths of a barcode and its symbols
    localparam int CODE_W     = 24;
    localparam int SYM_W      = 3;
    localparam int SYM_MAX    = CODE_W / SYM_W;
    localparam int CNT_W      = 4;
    localparam int LIMIT_W    = 4;
    localparam int NUM_ROUNDS = 3;

    // Stream payload widths
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 80;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_MATCH = 1'b1
    } opcode_t;

    // Result of one lane's table scan
    typedef struct packed {
        logic              done;
        logic              found;
        logic [CODE_W-1:0] code;
    } lane_res_t;

    // Count symbols that differ between two barcodes
    function automatic logic [CNT_W-1:0] count_mismatch(
        input logic [CODE_W-1:0] a,
        input logic [CODE_W-1:0] b
    );
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int s = 0; s < SYM_MAX; s++) begin
            if (a[s*SYM_W +: SYM_W] != b[s*SYM_W +: SYM_W])
            begin
                cnt = cnt + CNT_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ===== src/bhw_lane.sv =====
`default_nettype none
`include "assert_macros.svh"

module bhw_lane #(
    parameter int                           DEPTH     = 128,
    parameter logic [bhw_pkg::CODE_W-1:0]   CODE_MASK = '1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load_en,
    input  wire logic [bhw_pkg::CODE_W-1:0]     load_code,
    input  wire logic                           start,
    input  wire logic [bhw_pkg::CODE_W-1:0]     query,
    input  wire logic [bhw_pkg::LIMIT_W-1:0]    limit,
    output bhw_pkg::lane_res_t                  res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [bhw_pkg::CODE_W-1:0] mem [DEPTH];

    logic [FW-1:0]              fill_reg, fill_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic                       last_reg, last_next;
    logic [bhw_pkg::CODE_W-1:0] query_reg, query_next;
    logic [bhw_pkg::CODE_W-1:0] rdata_reg;
    logic                       found_reg, found_next;
    logic [bhw_pkg::CODE_W-1:0] code_reg, code_next;

    logic                       wr_en;
    logic [AW-1:0]              addr_inc;
    logic [AW-1:0]              rd_addr;
    logic [bhw_pkg::CNT_W-1:0]  mism;
    logic                       hit;
    logic                       finish;

    // Append only while the table has room
    assign wr_en    = load_en && (fill_reg < FW'(DEPTH));
    assign addr_inc = addr_reg + AW'(1);
    assign rd_addr  = start ? '0 : addr_inc;

    // Compare the entry read last cycle against the query
    assign mism   = bhw_pkg::count_mismatch(query_reg, rdata_reg);
    assign hit    = busy_reg && (mism <= limit);
    assign finish = busy_reg && (hit || last_reg);

    // Table storage with registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= load_code & CODE_MASK;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Scan control
    always_comb
    begin
        fill_next  = fill_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        addr_next  = addr_reg;
        last_next  = last_reg;
        query_next = query_reg;
        found_next = found_reg;
        code_next  = code_reg;

        if (wr_en)
        begin
            fill_next = fill_reg + FW'(1);
        end

        if (start)
        begin
            query_next = query & CODE_MASK;
            addr_next  = '0;
            last_next  = (fill_reg == FW'(1));
            if (fill_reg == '0)
            begin
                // Empty table: report not found at once
                done_next  = 1'b1;
                found_next = 1'b0;
                code_next  = '0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (finish)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = hit;
                code_next  = hit ? rdata_reg : '0;
            end
            else
            begin
                addr_next = addr_inc;
                last_next = (FW'(addr_inc) == (fill_reg - FW'(1)));
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold scan payload
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        last_reg  <= last_next;
        query_reg <= query_next;
        found_reg <= found_next;
        code_reg  <= code_next;
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.code  = code_reg;

    `BHW_ASSERT(a_addr_in_fill, clk, rst_n, !busy_reg || (FW'(addr_reg) < fill_reg),
        "lane scan address beyond table fill")
    `BHW_ASSERT(a_no_restart, clk, rst_n, !(start && busy_reg),
        "lane started while a scan is in progress")
    `BHW_ASSERT_NEXT(a_done_after_finish, clk, rst_n, finish, done_reg && !busy_reg,
        "lane finished without reporting a result")

endmodule

`default_nettype wire

// ===== src/bhw_merge.sv =====
`default_nettype none
`include "assert_macros.svh"

module bhw_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  bhw_pkg::lane_res_t                  lane_res [bhw_pkg::NUM_ROUNDS],
    output logic                                merge_load,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [bhw_pkg::M_DATA_W-1:0]        m_axis_tdata
);

    logic [bhw_pkg::NUM_ROUNDS-1:0] got_reg, got_next;
    logic [bhw_pkg::NUM_ROUNDS-1:0] found_reg, found_next;
    logic [bhw_pkg::CODE_W-1:0]     code_reg [bhw_pkg::NUM_ROUNDS];
    logic                           valid_reg, valid_next;
    logic [bhw_pkg::M_DATA_W-1:0]   data_reg;
    logic [bhw_pkg::M_DATA_W-1:0]   data_next;
    logic                           all_got;

    // Move to the output register once every lane has reported and it is free
    assign all_got    = &got_reg;
    assign merge_load = all_got && (!valid_reg || m_axis_tready);

    always_comb
    begin
        got_next   = got_reg;
        found_next = found_reg;
        for (int i = 0; i < bhw_pkg::NUM_ROUNDS; i++)
        begin
            if (lane_res[i].done)
            begin
                got_next[i]   = 1'b1;
                found_next[i] = lane_res[i].found;
            end
        end
        if (merge_load)
        begin
            got_next = '0;
        end

        valid_next = valid_reg;
        if (merge_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end

        // Pack flags, matched codes and the all-found flag
        data_next = {4'b0000, &found_reg,
                     code_reg[2], code_reg[1], code_reg[0],
                     found_reg[2], found_reg[1], found_reg[0]};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            got_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            got_reg   <= got_next;
            valid_reg <= valid_next;
        end
    end

    // Capture lane results and the output transaction
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        for (int i = 0; i < bhw_pkg::NUM_ROUNDS; i++)
        begin
            if (lane_res[i].done)
            begin
                code_reg[i] <= lane_res[i].code;
            end
        end
        if (merge_load)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    `BHW_ASSERT(a_no_double_report, clk, rst_n,
        !((lane_res[0].done && got_reg[0]) || (lane_res[1].done && got_reg[1]) ||
          (lane_res[2].done && got_reg[2])),
        "lane reported twice for one match")

endmodule

`default_nettype wire

// ===== src/hamming_barcode_whitelist_match.sv =====
`default_nettype none
`include "assert_macros.svh"

// Barcode whitelist matcher: three round tables of up to TABLE_DEPTH barcodes
// each, filled in load order by load transactions (loads into a full table or
// to table select 3 are dropped). A match transaction sends three query
// barcodes to three lanes that scan their tables side by side, one entry per
// cycle from each lane's memory read port, and stop at the first entry whose
// symbol mismatch count is at most mismatch_limit. Once all three lanes have
// reported and the output register is free, the merged result is stored there;
// the result becomes valid and the input ready again in the same cycle. No new
// input is taken from match acceptance until then, but loads and the next match
// proceed while the stored result waits for m_axis_tready. mismatch_limit is
// written through cfg_we/cfg_wdata and resets to 1; the user must write it only
// while the block is idle, which the block itself does not enforce.
module hamming_barcode_whitelist_match #(
    parameter int TABLE_DEPTH  = 128,
    parameter int CODE_SYMBOLS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bhw_pkg::LIMIT_W-1:0]         cfg_wdata,     // mismatch_limit
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // load_code[23:0], query_round_one[47:24], query_round_two[71:48],
    // query_round_three[95:72]
    input  wire logic [bhw_pkg::S_DATA_W-1:0]        s_axis_tdata,
    // opcode[0], table_select[2:1]
    input  wire logic [bhw_pkg::S_USER_W-1:0]        s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // found_one[0], found_two[1], found_three[2], matched_one[26:3],
    // matched_two[50:27], matched_three[74:51], all_found[75], zero fill[79:76]
    output logic [bhw_pkg::M_DATA_W-1:0]             m_axis_tdata
);

    localparam int CODE_BITS = 3 * CODE_SYMBOLS;
    localparam int EFF_BITS  = (CODE_BITS < bhw_pkg::CODE_W) ? CODE_BITS : bhw_pkg::CODE_W;
    localparam logic [bhw_pkg::CODE_W-1:0] CODE_MASK =
        bhw_pkg::CODE_W'((64'd1 << EFF_BITS) - 64'd1);

    logic [bhw_pkg::LIMIT_W-1:0] limit_reg;
    logic                        active_reg, active_next;
    logic                        in_accept;
    bhw_pkg::opcode_t            opcode;
    logic [1:0]                  table_select;
    logic                        start;
    logic                        merge_load;
    bhw_pkg::lane_res_t          lane_res [bhw_pkg::NUM_ROUNDS];

    // Decode the input transaction
    assign s_axis_tready = !active_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign opcode        = bhw_pkg::opcode_t'(s_axis_tuser[0]);
    assign table_select  = s_axis_tuser[2:1];
    assign start         = in_accept && (opcode == bhw_pkg::OP_MATCH);

    // Block input from match start until the merged result is stored
    always_comb
    begin
        active_next = active_reg;
        if (start)
        begin
            active_next = 1'b1;
        end
        else if (merge_load)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            limit_reg  <= bhw_pkg::LIMIT_RESET;
        end
        else
        begin
            active_reg <= active_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // One scanning lane per round table
    for (genvar i = 0; i < bhw_pkg::NUM_ROUNDS; i++)
    begin : g_lane
        logic load_en;

        assign load_en = in_accept && (opcode == bhw_pkg::OP_LOAD) &&
                         (table_select == 2'(i));

        bhw_lane #(
            .DEPTH     (TABLE_DEPTH),
            .CODE_MASK (CODE_MASK)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (load_en),
            .load_code (s_axis_tdata[bhw_pkg::CODE_W-1:0]),
            .start     (start),
            .query     (s_axis_tdata[(i+1)*bhw_pkg::CODE_W +: bhw_pkg::CODE_W]),
            .limit     (limit_reg),
            .res       (lane_res[i])
        );
    end

    // Merge lane results into the output register
    bhw_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_res      (lane_res),
        .merge_load    (merge_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `BHW_ASSERT(a_load_only_when_active, clk, rst_n, !merge_load || active_reg,
        "result merged with no match in progress")

endmodule

`default_nettype wire
